// ----- rtl/core/hmac_auth_pkg.sv -----
`timescale 1ns / 1ps
// Package for the HMAC-SHA256 challenge-response authenticator.
// Holds SHA-256 constants, codes and a rotate helper function; no dependencies.
package hmac_auth_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [7:0] OP_BEGIN    = 8'h01;
  localparam logic [7:0] OP_RESPONSE = 8'h02;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CHAL   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;

  localparam logic [1:0] SESS_IDLE = 2'd0;
  localparam logic [1:0] SESS_CHAL = 2'd1;
  localparam logic [1:0] SESS_AUTH = 2'd2;

  localparam logic [2:0] REG_MAXF = 3'd4;
  localparam logic [2:0] REG_LOCK = 3'd5;

  localparam logic [9:0] RESP_LEN = 10'd33;
  localparam logic [3:0] MAXF_RESET = 4'd3;
  localparam logic [23:0] LOCK_RESET = 24'd30000;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  typedef logic [31:0] word_t;
  typedef logic [511:0] block_t;
  typedef logic [255:0] digest_t;

  // Command from the controller to the hash core.
  typedef struct packed {
    logic   start;
    logic   init;
    block_t blk;
  } hash_cmd_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/core/hmac_auth_sha.sv -----
`timescale 1ns / 1ps
// SHA-256 compression unit: one round per cycle, 64 rounds per block.
// Depends on hmac_auth_pkg.
module hmac_auth_sha import hmac_auth_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hash_cmd_t cmd,
  output logic      done,
  output digest_t   digest
);

  word_t h_r [8];
  word_t v_r [8];
  word_t w_r [16];
  logic [5:0] rnd_r;
  logic busy_r, done_r;

  word_t wt, t1, t2, s0, s1, wa, wb;

  always_comb begin
    wa = w_r[14];
    wb = w_r[1];
    if (busy_r) begin
      wt = (rotr(wa, 17) ^ rotr(wa, 19) ^ (wa >> 10)) + w_r[9] +
           (rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3)) + w_r[0];
    end else begin
      wt = 32'd0;
    end
    if (rnd_r < 6'd16) begin
      wt = w_r[0];
    end
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    t1 = v_r[7] + s1 + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RK[rnd_r] + wt;
    t2 = s0 + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= busy_r && !cmd.start && (rnd_r == 6'd63);
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= cmd.blk[511 - 32 * i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        if (cmd.init) begin
          h_r[i] <= IV[i];
          v_r[i] <= IV[i];
        end else begin
          v_r[i] <= h_r[i];
        end
      end
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= wt;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (done_r) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  // Digest is valid in the cycle after done, provided no start arrives with done.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest[255 - 32 * i -: 32] = h_r[i];
    end
  end
  assign done = done_r;

endmodule

// ----- rtl/core/hmac_challenge_response_auth.sv -----
`timescale 1ns / 1ps
// Top level of the HMAC-SHA256 challenge-response authenticator.
// Depends on hmac_auth_pkg and hmac_auth_sha.
// Ticks, session resets and writes other than a checked response offer their result
// in the cycle after the transfer. A checked response runs four SHA-256 compressions
// in turn on one shared round unit at one round per cycle, each through S_WAIT and
// S_HASH; S_CMP then compares the digest, and S_OUT offers the result. The block takes
// one item at a time and is not ready while an item is in flight or a result waits.
module hmac_challenge_response_auth import hmac_auth_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_opcode,
  input  logic [9:0]  in_length,
  input  logic [63:0] in_response_word0,
  input  logic [63:0] in_response_word1,
  input  logic [63:0] in_response_word2,
  input  logic [63:0] in_response_word3,
  input  logic [63:0] in_random_word0,
  input  logic [63:0] in_random_word1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_notify_kind,
  output logic [1:0]  out_status,
  output logic [63:0] out_challenge_word0,
  output logic [63:0] out_challenge_word1,
  output logic        out_accepted,
  output logic        out_authenticated,
  output logic        out_locked_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [1:0] step_r;
  logic [255:0] secret_r;
  logic [3:0] maxf_r, fail_r;
  logic [23:0] lockt_r, lockrem_r;
  logic [1:0] sess_r;
  logic [127:0] chal_r;
  logic [255:0] resp_r, inner_r;
  logic [1:0] kind_r, status_r;
  logic [127:0] ochal_r;
  logic acc_r;

  hash_cmd_t cmd;
  logic hdone;
  digest_t digest;
  logic [511:0] key_blk;

  logic is_write, is_lock, is_begin, is_resp, is_check;

  assign key_blk = {secret_r, 256'd0};

  assign is_write = (in_mode == MODE_WRITE) && (in_length != 10'd0);
  assign is_lock  = is_write && (lockrem_r != 24'd0);
  assign is_begin = is_write && !is_lock && (in_opcode == OP_BEGIN);
  assign is_resp  = is_write && !is_lock && (in_opcode == OP_RESPONSE);
  assign is_check = is_resp && (sess_r == SESS_CHAL) && (in_length == RESP_LEN);

  always_comb begin
    cmd.start = 1'b0;
    cmd.init  = 1'b0;
    cmd.blk   = '0;
    if (state_r == S_WAIT) begin
      cmd.start = 1'b1;
      case (step_r)
        2'd0: begin
          cmd.init = 1'b1;
          cmd.blk  = key_blk ^ {64{IPAD}};
        end
        2'd1: cmd.blk = {chal_r, 8'h80, 360'd0, 16'd640};
        2'd2: begin
          cmd.init = 1'b1;
          cmd.blk  = key_blk ^ {64{OPAD}};
        end
        default: cmd.blk = {inner_r, 8'h80, 232'd0, 16'd768};
      endcase
    end
  end

  hmac_auth_sha u_sha (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .done(hdone), .digest(digest));

  logic hdone_d_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      secret_r  <= '0;
      maxf_r    <= MAXF_RESET;
      lockt_r   <= LOCK_RESET;
      fail_r    <= '0;
      lockrem_r <= '0;
      sess_r    <= SESS_IDLE;
      chal_r    <= '0;
      hdone_d_r <= 1'b0;
    end else begin
      hdone_d_r <= hdone;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_MAXF) begin
          secret_r[255 - 64 * cfg_index[1:0] -: 64] <= cfg_data;
        end else if (cfg_index == REG_MAXF) begin
          maxf_r <= cfg_data[3:0];
        end else if (cfg_index == REG_LOCK) begin
          lockt_r <= cfg_data[23:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= (is_lock || is_resp) ? KIND_STATUS :
                        (is_begin ? KIND_CHAL : KIND_NONE);
            status_r <= is_lock ? ST_LOCKED : ((is_resp && !is_check) ? ST_FAIL : ST_OK);
            ochal_r  <= is_begin ? {in_random_word0, in_random_word1} : 128'd0;
            acc_r    <= is_lock || is_begin;
            resp_r   <= {in_response_word0, in_response_word1,
                         in_response_word2, in_response_word3};
            state_r  <= is_check ? S_WAIT : S_OUT;
            if (is_check) step_r <= '0;
            if (in_mode == MODE_TICK) begin
              if (lockrem_r != 24'd0) lockrem_r <= lockrem_r - 24'd1;
            end else if (in_mode == MODE_RESET) begin
              sess_r <= SESS_IDLE;
              chal_r <= '0;
            end else if (is_begin) begin
              chal_r <= {in_random_word0, in_random_word1};
              sess_r <= SESS_CHAL;
            end
          end
        end
        S_WAIT: state_r <= S_HASH;
        S_HASH: begin
          if (hdone_d_r) begin
            step_r <= step_r + 2'd1;
            if (step_r == 2'd1) inner_r <= digest;
            state_r <= (step_r == 2'd3) ? S_CMP : S_WAIT;
          end
        end
        S_CMP: begin
          acc_r   <= 1'b1;
          state_r <= S_OUT;
          if (digest == resp_r) begin
            sess_r   <= SESS_AUTH;
            fail_r   <= '0;
            status_r <= ST_OK;
          end else begin
            sess_r <= SESS_IDLE;
            if (fail_r + 4'd1 >= maxf_r) begin
              lockrem_r <= lockt_r;
              fail_r    <= '0;
              status_r  <= ST_LOCKED;
            end else begin
              fail_r   <= fail_r + 4'd1;
              status_r <= ST_FAIL;
            end
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_notify_kind     = kind_r;
  assign out_status          = status_r;
  assign out_challenge_word0 = ochal_r[127:64];
  assign out_challenge_word1 = ochal_r[63:0];
  assign out_accepted        = acc_r;
  assign out_authenticated   = (sess_r == SESS_AUTH);
  assign out_locked_out      = (lockrem_r != 24'd0);

endmodule

// ----- rtl/core/hmac_auth_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the authenticator, bound to the top level.
// Depends on hmac_auth_pkg.
module hmac_auth_checker import hmac_auth_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_notify_kind,
  input logic [1:0] out_status,
  input logic       out_accepted
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  a_result_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after transfer");

  a_locked_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_LOCKED) |-> out_accepted)
    else $error("locked status not accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_notify_kind)))
    else $error("result dropped while stalled");

endmodule

bind hmac_challenge_response_auth hmac_auth_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_notify_kind(out_notify_kind),
  .out_status(out_status), .out_accepted(out_accepted));
